// File: design/date_day_distance_macros.svh
// Assertion macros used by the checker file of the date distance block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef DATE_DAY_DISTANCE_MACROS_SVH
`define DATE_DAY_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dd_pkg.sv
// Package for the date day distance block: payload types, widths and calendar tables.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dd_pkg;

  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned DistW   = 22;
  // Wide enough for the serial day of any 14-bit year, valid or not.
  localparam int unsigned SerialW = 23;
  localparam int unsigned QuotW   = YearW - 2;
  localparam int unsigned DbmW    = 9;

  localparam int unsigned MaxYear = 9999;

  localparam logic [DistW-1:0]  DistMax    = '1;
  localparam logic [MonthW-1:0] MonthFirst = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
  localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);

  // Reciprocal of 25 scaled by 2^16; exact for every dividend below 4681.
  localparam int unsigned Div25Mult  = 2622;
  localparam int unsigned Div25Shift = 16;
  localparam int unsigned Div25ProdW = QuotW + 12;

  typedef struct packed {
    logic [DayW-1:0]   first_day;
    logic [MonthW-1:0] first_month;
    logic [YearW-1:0]  first_year;
    logic [DayW-1:0]   second_day;
    logic [MonthW-1:0] second_month;
    logic [YearW-1:0]  second_year;
  } dd_in_t;

  typedef struct packed {
    logic [DistW-1:0] day_distance;
    logic             dates_valid;
  } dd_out_t;

  function automatic logic [QuotW-1:0] div25(input logic [QuotW-1:0] v);
    logic [Div25ProdW-1:0] prod;
    prod = Div25ProdW'(v) * Div25ProdW'(Div25Mult);
    return QuotW'(prod >> Div25Shift);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      MonthFeb: len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DayW'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [DbmW-1:0] days_before_month(input logic [MonthW-1:0] m);
    logic [DbmW-1:0] dbm;
    case (m)
      4'd1:    dbm = DbmW'(0);
      4'd2:    dbm = DbmW'(31);
      4'd3:    dbm = DbmW'(59);
      4'd4:    dbm = DbmW'(90);
      4'd5:    dbm = DbmW'(120);
      4'd6:    dbm = DbmW'(151);
      4'd7:    dbm = DbmW'(181);
      4'd8:    dbm = DbmW'(212);
      4'd9:    dbm = DbmW'(243);
      4'd10:   dbm = DbmW'(273);
      4'd11:   dbm = DbmW'(304);
      4'd12:   dbm = DbmW'(334);
      default: dbm = '0;
    endcase
    return dbm;
  endfunction

endpackage

`default_nettype wire

// File: design/date_day_distance.sv
// Top level of the date day distance block: input register, two date evaluators,
// the distance stage and the result register. Depends on dd_pkg, dd_date_eval, dd_distance.
//
// Usage:
//   Input channel (in_valid_i, in_ready_o, in_data_i) carries two dates per transaction.
//   Output channel (out_valid_o, out_ready_i, out_data_o) returns one result per input:
//   the absolute day distance and a flag that both dates are valid. An invalid date
//   gives a distance of zero.
//   The result passes from the input register to the result register and then shows on
//   out_valid_o; a stall on the output side can hold it in the input register first.
//   Throughput is one transaction per cycle while the receiver does not stall; the single
//   combinational pass from the input register to the result register sets that figure.
//   When the receiver stalls, the result register holds its transaction and the input
//   register can still take one more; in_ready_o falls only when both are full.
//   While out_ready_i is high, in_ready_o is high.
//   Reset empties both registers; the block keeps no other state.
`default_nettype none

module date_day_distance import dd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dd_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dd_out_t out_data_o
);

  logic    in_valid_q;
  dd_in_t  in_data_q;
  logic    out_valid_q;
  dd_out_t out_data_q;
  logic    out_free;
  logic    advance;
  dd_out_t result_d;

  logic [SerialW-1:0] serial_a, serial_b;
  logic               valid_a, valid_b;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  dd_date_eval u_first (
    .day_i    (in_data_q.first_day),
    .month_i  (in_data_q.first_month),
    .year_i   (in_data_q.first_year),
    .serial_o (serial_a),
    .valid_o  (valid_a)
  );

  dd_date_eval u_second (
    .day_i    (in_data_q.second_day),
    .month_i  (in_data_q.second_month),
    .year_i   (in_data_q.second_year),
    .serial_o (serial_b),
    .valid_o  (valid_b)
  );

  dd_distance u_dist (
    .serial_a_i (serial_a),
    .serial_b_i (serial_b),
    .valid_a_i  (valid_a),
    .valid_b_i  (valid_b),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: design/dd_date_eval.sv
// Checks one Gregorian date and turns it into its serial day count.
// Depends on dd_pkg for widths, the divide-by-25 helper and the month tables.
`default_nettype none

module dd_date_eval import dd_pkg::*; (
  input  logic [DayW-1:0]    day_i,
  input  logic [MonthW-1:0]  month_i,
  input  logic [YearW-1:0]   year_i,
  output logic [SerialW-1:0] serial_o,
  output logic               valid_o
);

  logic [QuotW-1:0] year_q4;
  logic [QuotW-1:0] year_c;
  logic             div4, div100, div400, leap;
  logic [YearW-1:0] prev_year;
  logic [QuotW-1:0] prev_q4;
  logic [QuotW-1:0] prev_c;
  logic [DayW-1:0]  len;

  // Year divides by 100 when it divides by 4 and the quarter divides by 25.
  assign year_q4 = year_i[YearW-1:2];
  assign year_c  = div25(year_q4);
  assign div4    = (year_i[1:0] == 2'b00);
  assign div100  = div4 && (year_q4 == QuotW'(year_c * QuotW'(25)));
  assign div400  = div100 && (year_c[1:0] == 2'b00);
  assign leap    = (div4 && !div100) || div400;

  assign len = month_len(month_i, leap);

  assign valid_o = (year_i != '0) && (year_i <= YearW'(MaxYear)) &&
                   (month_i >= MonthFirst) && (month_i <= MonthLast) &&
                   (day_i != '0) && (day_i <= len);

  // Whole years before this one; floor(p/400) is floor(floor(p/100)/4).
  assign prev_year = year_i - YearW'(1);
  assign prev_q4   = prev_year[YearW-1:2];
  assign prev_c    = div25(prev_q4);

  assign serial_o = SerialW'(prev_year) * SerialW'(365)
                  + SerialW'(prev_q4)
                  - SerialW'(prev_c)
                  + SerialW'(prev_c[QuotW-1:2])
                  + SerialW'(days_before_month(month_i))
                  + SerialW'(leap && (month_i > MonthFeb))
                  + SerialW'(day_i);

endmodule

`default_nettype wire

// File: design/dd_distance.sv
// Forms the absolute difference of two serial day counts, saturated and masked by validity.
// Depends on dd_pkg for widths and the result type.
`default_nettype none

module dd_distance import dd_pkg::*; (
  input  logic [SerialW-1:0] serial_a_i,
  input  logic [SerialW-1:0] serial_b_i,
  input  logic               valid_a_i,
  input  logic               valid_b_i,
  output dd_out_t            result_o
);

  logic [SerialW-1:0] diff;
  logic               ok;

  assign diff = (serial_a_i >= serial_b_i) ? (serial_a_i - serial_b_i)
                                           : (serial_b_i - serial_a_i);
  assign ok   = valid_a_i && valid_b_i;

  always_comb begin
    result_o.dates_valid = ok;
    if (!ok) begin
      result_o.day_distance = '0;
    end else if (diff > SerialW'(DistMax)) begin
      result_o.day_distance = DistMax;
    end else begin
      result_o.day_distance = diff[DistW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: design/dd_checker.sv
// Port-level checker for the date day distance block, bound to the top level.
// Depends on dd_pkg and the assertion macros in date_day_distance_macros.svh.
`default_nettype none
`include "date_day_distance_macros.svh"

module dd_checker import dd_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_ready_o,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input dd_out_t out_data_o
);

  `DD_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `DD_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed while stalled")
  `DD_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, out_valid_o && !out_data_o.dates_valid, out_data_o.day_distance == '0, "invalid dates gave a nonzero distance")
  `DD_ASSERT_NOW(a_ready_follows, clk_i, rst_ni, out_ready_i, in_ready_o, "input stalled while the output side is ready")

endmodule

bind date_day_distance dd_checker u_dd_checker (.*);

`default_nettype wire
